// File: src/pose_to_affine_matrix_assert.svh
// Assertion macros shared by the pose-to-affine-matrix RTL.
// Each file that asserts includes this header; the file must have clk and arst_n in scope.
`ifndef POSE_TO_AFFINE_MATRIX_ASSERT_SVH
`define POSE_TO_AFFINE_MATRIX_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define P2AM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define P2AM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/p2am_pkg.sv
// Package for the pose-to-affine-matrix block: widths, the CORDIC arctangent table,
// the queued item type and the saturation helper. No dependencies.
`timescale 1ns / 1ps

package p2am_pkg;

	localparam int ATAN_LEN = 30;
	localparam int XW       = 34;   // CORDIC x and y, Q2.30 with headroom
	localparam int ZW       = 33;   // CORDIC angle residue, 2^-32 turn units
	localparam int PW       = 36;   // scale times sine or cosine, rounded
	localparam int QW       = 68;   // origin products and translation sums
	localparam int LO_W     = 17;   // low slice of a split multiplication

	localparam logic signed [XW-1:0] CORDIC_X0 = 34'sd652032874;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic signed [QW-1:0] SAT_MAX = 68'sh0_0000_0000_7FFF_FFFF;
	localparam logic signed [QW-1:0] SAT_MIN = -68'sh0_0000_0000_8000_0000;

	typedef struct packed {
		logic signed [31:0]   ox;
		logic signed [31:0]   oy;
		logic signed [31:0]   px;
		logic signed [31:0]   py;
		logic signed [31:0]   sx;
		logic signed [31:0]   sy;
		logic signed [ZW-1:0] z0;
		logic                 flip;
	} item_t;

	function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] idx);
		logic signed [ZW-1:0] r;
		case (idx)
			5'd0:  r = 33'sh020000000;
			5'd1:  r = 33'sh012E4051E;
			5'd2:  r = 33'sh009FB385B;
			5'd3:  r = 33'sh0051111D4;
			5'd4:  r = 33'sh0028B0D43;
			5'd5:  r = 33'sh00145D7E1;
			5'd6:  r = 33'sh000A2F61E;
			5'd7:  r = 33'sh000517C55;
			5'd8:  r = 33'sh00028BE53;
			5'd9:  r = 33'sh000145F2F;
			5'd10: r = 33'sh0000A2F98;
			5'd11: r = 33'sh0000517CC;
			5'd12: r = 33'sh000028BE6;
			5'd13: r = 33'sh0000145F3;
			5'd14: r = 33'sh00000A2FA;
			5'd15: r = 33'sh00000517D;
			5'd16: r = 33'sh0000028BE;
			5'd17: r = 33'sh00000145F;
			5'd18: r = 33'sh000000A30;
			5'd19: r = 33'sh000000518;
			5'd20: r = 33'sh00000028C;
			5'd21: r = 33'sh000000146;
			5'd22: r = 33'sh0000000A3;
			5'd23: r = 33'sh000000051;
			5'd24: r = 33'sh000000029;
			5'd25: r = 33'sh000000014;
			5'd26: r = 33'sh00000000A;
			5'd27: r = 33'sh000000005;
			5'd28: r = 33'sh000000003;
			5'd29: r = 33'sh000000001;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [QW-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: src/p2am_front.sv
// Front end: accepts a pose, negates the angle, folds it into the right half plane.
// Depends on p2am_pkg.
`timescale 1ns / 1ps

module p2am_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [31:0]    origin_x,
	input  logic signed [31:0]    origin_y,
	input  logic signed [31:0]    position_x,
	input  logic signed [31:0]    position_y,
	input  logic [15:0]           rotation_angle,
	input  logic signed [31:0]    scale_x,
	input  logic signed [31:0]    scale_y,
	output logic                  push_valid,
	input  logic                  push_ready,
	output p2am_pkg::item_t       push_item
);

	logic            v_s1;
	p2am_pkg::item_t item_s1;
	p2am_pkg::item_t item_d;
	logic [15:0]     ang;
	logic [31:0]     turn;
	logic            flip;
	logic [31:0]     turn_u;

	always_comb begin
		ang    = 16'(16'd0 - rotation_angle);
		turn   = {ang, 16'h0000};
		// Angles in the left half plane are turned by a half turn and the result negated.
		flip   = turn[31] ^ turn[30];
		turn_u = {turn[31] ^ flip, turn[30:0]};
		item_d.ox   = origin_x;
		item_d.oy   = origin_y;
		item_d.px   = position_x;
		item_d.py   = position_y;
		item_d.sx   = scale_x;
		item_d.sy   = scale_y;
		item_d.z0   = p2am_pkg::ZW'($signed(turn_u));
		item_d.flip = flip;
	end

	assign in_ready   = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: src/p2am_queue.sv
// Short queue between the front end and the arithmetic back end.
// Depends on p2am_pkg and pose_to_affine_matrix_assert.svh.
`timescale 1ns / 1ps
`include "pose_to_affine_matrix_assert.svh"

module p2am_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  p2am_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output p2am_pkg::item_t pop_item
);

	p2am_pkg::item_t                  mem_q [p2am_pkg::QDEPTH];
	logic [p2am_pkg::QPTR_W-1:0]      wr_q;
	logic [p2am_pkg::QPTR_W-1:0]      rd_q;
	logic [p2am_pkg::QCNT_W-1:0]      cnt_q;
	logic                             push;
	logic                             pop;
	logic                             full;

	assign full       = (cnt_q == p2am_pkg::QCNT_W'(p2am_pkg::QDEPTH));
	assign push_ready = !full;
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	`P2AM_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= p2am_pkg::QCNT_W'(p2am_pkg::QDEPTH), "overfilled")
	`P2AM_ASSERT_ALWAYS(a_ptr_match, (wr_q - rd_q) == cnt_q[p2am_pkg::QPTR_W-1:0], "pointer skew")
	`P2AM_ASSERT_NEXT(a_full_holds, full && !pop_ready, full, "full queue drained without a pop")

endmodule

// File: src/p2am_back.sv
// Back end: pipelined CORDIC, scale products, origin products and saturation.
// Depends on p2am_pkg.
`timescale 1ns / 1ps

module p2am_back #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  p2am_pkg::item_t    in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] entry_a,
	output logic signed [31:0] entry_b,
	output logic signed [31:0] entry_tx,
	output logic signed [31:0] entry_c,
	output logic signed [31:0] entry_d,
	output logic signed [31:0] entry_ty
);

	localparam int XW    = p2am_pkg::XW;
	localparam int ZW    = p2am_pkg::ZW;
	localparam int PW    = p2am_pkg::PW;
	localparam int QW    = p2am_pkg::QW;
	localparam int LO_W  = p2am_pkg::LO_W;
	localparam int HI_W  = PW - LO_W;
	localparam int MW    = 32 + XW;
	localparam int NSTEP = (CORDIC_STEPS < p2am_pkg::ATAN_LEN) ? CORDIC_STEPS
	                                                          : p2am_pkg::ATAN_LEN;
	localparam int LAT   = NSTEP + 6;
	localparam logic signed [MW-1:0] RND30 = MW'(64'sd536870912);
	localparam logic signed [QW-1:0] HALF  = QW'(64'd1 << (FRAC_BITS - 1));

	logic [LAT-1:0] v_q;
	logic           en;

	assign en        = !v_q[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = v_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], in_valid};
		end
	end

	// CORDIC rotation stages, one micro-rotation per register stage.
	logic signed [XW-1:0] cx_q [0:NSTEP];
	logic signed [XW-1:0] cy_q [0:NSTEP];
	logic signed [ZW-1:0] cz_q [0:NSTEP];
	p2am_pkg::item_t      ci_q [0:NSTEP];

	always_ff @(posedge clk) begin
		if (en) begin
			cx_q[0] <= p2am_pkg::CORDIC_X0;
			cy_q[0] <= '0;
			cz_q[0] <= in_item.z0;
			ci_q[0] <= in_item;
		end
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_q[k][ZW-1]) begin
					cx_q[k+1] <= cx_q[k] - (cy_q[k] >>> k);
					cy_q[k+1] <= cy_q[k] + (cx_q[k] >>> k);
					cz_q[k+1] <= cz_q[k] - p2am_pkg::atan_turn(5'(k));
				end else begin
					cx_q[k+1] <= cx_q[k] + (cy_q[k] >>> k);
					cy_q[k+1] <= cy_q[k] - (cx_q[k] >>> k);
					cz_q[k+1] <= cz_q[k] + p2am_pkg::atan_turn(5'(k));
				end
				ci_q[k+1] <= ci_q[k];
			end
		end
	end

	// Stage 1: scale times cosine and sine at full width.
	logic signed [XW-1:0] cos_v;
	logic signed [XW-1:0] sin_v;
	logic signed [MW-1:0] p_s1 [4];
	p2am_pkg::item_t      i_s1;

	always_comb begin
		cos_v = ci_q[NSTEP].flip ? -cx_q[NSTEP] : cx_q[NSTEP];
		sin_v = ci_q[NSTEP].flip ? -cy_q[NSTEP] : cy_q[NSTEP];
	end

	// Order of the four terms: sx*c, sy*s, sx*s, sy*c.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= ci_q[NSTEP].sx * cos_v;
			p_s1[1] <= ci_q[NSTEP].sy * sin_v;
			p_s1[2] <= ci_q[NSTEP].sx * sin_v;
			p_s1[3] <= ci_q[NSTEP].sy * cos_v;
			i_s1    <= ci_q[NSTEP];
		end
	end

	// Stage 2: round back to the coordinate format.
	logic signed [PW-1:0] t_s2 [4];
	p2am_pkg::item_t      i_s2;

	for (genvar j = 0; j < 4; j++) begin : g_round
		always_ff @(posedge clk) begin
			if (en) begin
				t_s2[j] <= PW'((p_s1[j] + RND30) >>> 30);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s2 <= i_s1;
		end
	end

	// The four matrix entries that need no translation are saturated here.
	logic signed [31:0] lin_d [4];
	always_comb begin
		lin_d[0] = p2am_pkg::sat32(QW'(t_s2[0]));
		lin_d[1] = p2am_pkg::sat32(QW'(t_s2[1]));
		lin_d[2] = p2am_pkg::sat32(-QW'(t_s2[2]));
		lin_d[3] = p2am_pkg::sat32(QW'(t_s2[3]));
	end

	// Stage 3: origin products, each split into two narrow multiplications.
	logic signed [31+HI_W:0] hi_s3 [4];
	logic signed [31+HI_W:0] lo_s3 [4];
	logic signed [31:0]      lin_s3 [4];
	p2am_pkg::item_t         i_s3;
	logic signed [31:0]      org_v [4];

	always_comb begin
		org_v[0] = i_s2.ox;
		org_v[1] = i_s2.oy;
		org_v[2] = i_s2.ox;
		org_v[3] = i_s2.oy;
	end

	for (genvar j = 0; j < 4; j++) begin : g_split
		logic signed [HI_W-1:0] hi_part;
		logic signed [LO_W:0]   lo_part;
		assign hi_part = t_s2[j][PW-1:LO_W];
		assign lo_part = $signed({1'b0, t_s2[j][LO_W-1:0]});
		always_ff @(posedge clk) begin
			if (en) begin
				hi_s3[j]  <= org_v[j] * hi_part;
				lo_s3[j]  <= org_v[j] * lo_part;
				lin_s3[j] <= lin_d[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s3 <= i_s2;
		end
	end

	// Stage 4: recombine and round each origin product to the coordinate format.
	logic signed [QW-1:0] q_s4 [4];
	logic signed [31:0]   lin_s4 [4];
	p2am_pkg::item_t      i_s4;

	for (genvar j = 0; j < 4; j++) begin : g_comb
		always_ff @(posedge clk) begin
			if (en) begin
				q_s4[j]   <= ((QW'(hi_s3[j]) <<< LO_W) + QW'(lo_s3[j]) + HALF) >>> FRAC_BITS;
				lin_s4[j] <= lin_s3[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			i_s4 <= i_s3;
		end
	end

	// Stage 5: translation sums and the output register.
	logic signed [31:0] a_s5, b_s5, c_s5, d_s5, tx_s5, ty_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5  <= lin_s4[0];
			b_s5  <= lin_s4[1];
			c_s5  <= lin_s4[2];
			d_s5  <= lin_s4[3];
			tx_s5 <= p2am_pkg::sat32(QW'(i_s4.px) - q_s4[0] - q_s4[1]);
			ty_s5 <= p2am_pkg::sat32(QW'(i_s4.py) + q_s4[2] - q_s4[3]);
		end
	end

	assign entry_a  = a_s5;
	assign entry_b  = b_s5;
	assign entry_c  = c_s5;
	assign entry_d  = d_s5;
	assign entry_tx = tx_s5;
	assign entry_ty = ty_s5;

endmodule

// File: src/pose_to_affine_matrix.sv
// Top level of the pose-to-affine-matrix block.
// Instantiates p2am_front, p2am_queue and p2am_back; depends on p2am_pkg.
`timescale 1ns / 1ps

// Each transfer on the input channel carries one 2D pose: origin, position, rotation
// angle (65536 is a full turn) and per-axis scale, all coordinates and scales in signed
// fixed point with FRAC_BITS fraction bits. For every pose the block returns exactly one
// transfer holding the six entries of the top two rows of the affine matrix, each
// saturated to 32 bits, in input order. The block takes one pose per clock cycle when
// the output side keeps up. A pose passes through the front register, then the
// four-entry queue, and then the back-end pipeline: an input register, one register
// per CORDIC micro-rotation, then the scale multipliers, rounding, the split origin
// multipliers, their recombination and the translation adders with the output register.
// When the output is stalled the whole back-end pipeline holds, and the queue and front
// register absorb up to five more poses before the input side stalls.
module pose_to_affine_matrix #(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] position_x,
	input  logic signed [31:0] position_y,
	input  logic [15:0]        rotation_angle,
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] entry_a,
	output logic signed [31:0] entry_b,
	output logic signed [31:0] entry_tx,
	output logic signed [31:0] entry_c,
	output logic signed [31:0] entry_d,
	output logic signed [31:0] entry_ty
);

	logic            push_valid;
	logic            push_ready;
	p2am_pkg::item_t push_item;
	logic            pop_valid;
	logic            pop_ready;
	p2am_pkg::item_t pop_item;

	p2am_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.origin_x       (origin_x),
		.origin_y       (origin_y),
		.position_x     (position_x),
		.position_y     (position_y),
		.rotation_angle (rotation_angle),
		.scale_x        (scale_x),
		.scale_y        (scale_y),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_item      (push_item)
	);

	// The queue lets the front keep accepting poses while the back end holds a result.
	p2am_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	p2am_back #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pop_valid),
		.in_ready  (pop_ready),
		.in_item   (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.entry_a   (entry_a),
		.entry_b   (entry_b),
		.entry_tx  (entry_tx),
		.entry_c   (entry_c),
		.entry_d   (entry_d),
		.entry_ty  (entry_ty)
	);

endmodule
